// File: src/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types and constants of the circle pair collision resolver: status
// codes, the per-stage pipeline record and the output item.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    // fraction bits of the unit normal and of the mass ratios
    localparam int NB     = 28;
    // quotient bits produced by the long dividers
    localparam int QW     = 30;
    // bits of the integer square root
    localparam int ROOT_W = 32;

    localparam logic [QW-1:0] K_ONE = QW'(64'd1 << NB);

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_RESOLVED   = 2'd1,
        ST_COINCIDENT = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] pa_x;
        logic signed [31:0] pa_y;
        logic signed [31:0] va_x;
        logic signed [31:0] va_y;
        logic signed [31:0] pb_x;
        logic signed [31:0] pb_y;
        logic signed [31:0] vb_x;
        logic signed [31:0] vb_y;
        logic [30:0]        ma;
        logic [30:0]        mb;
        logic               neg_x;
        logic               neg_y;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [31:0]        rsum;
        logic [31:0]        msum;
        logic [31:0]        pen;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        rr;
        logic [63:0]        rad;
        logic [33:0]        srem;
        logic [ROOT_W-1:0]  root;
        logic [3:0][31:0]   rem;
        logic [3:0][QW-1:0] quo;
        logic signed [QW-1:0] nx;
        logic signed [QW-1:0] ny;
        logic [QW-1:0]      ka;
        logic [QW-1:0]      kb;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
        logic signed [62:0] prx;
        logic signed [62:0] pry;
        logic signed [62:0] ppx;
        logic signed [62:0] ppy;
        logic signed [35:0] u;
        logic signed [32:0] px;
        logic signed [32:0] py;
        logic signed [63:0] pja;
        logic signed [63:0] pjb;
        logic signed [35:0] ja;
        logic signed [35:0] jb;
        logic signed [63:0] qax;
        logic signed [63:0] qay;
        logic signed [63:0] qbx;
        logic signed [63:0] qby;
        logic signed [35:0] dax;
        logic signed [35:0] day;
        logic signed [35:0] dbx;
        logic signed [35:0] dby;
    } rec_t;

    typedef struct packed {
        logic signed [31:0] pa_x;
        logic signed [31:0] pa_y;
        logic signed [31:0] va_x;
        logic signed [31:0] va_y;
        logic signed [31:0] pb_x;
        logic signed [31:0] pb_y;
        logic signed [31:0] vb_x;
        logic signed [31:0] vb_y;
        status_t            status;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -38'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: src/cpcr_if.sv
// ----------------------------------------------------------------------------
// cpcr_if
// Valid/ready channels of the resolver: the circle pair in, the result out.
// ----------------------------------------------------------------------------
interface cpcr_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic [30:0]        mass_a;
    logic [30:0]        radius_a;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [30:0]        mass_b;
    logic [30:0]        radius_b;

    modport source (
        output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, mass_a, radius_a,
               pos_b_x, pos_b_y, vel_b_x, vel_b_y, mass_b, radius_b,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, mass_a, radius_a,
               pos_b_x, pos_b_y, vel_b_x, vel_b_y, mass_b, radius_b,
        output ready
    );
endinterface

interface cpcr_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_a_x;
    logic signed [31:0] new_pos_a_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_pos_b_x;
    logic signed [31:0] new_pos_b_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic [1:0]         contact_status;

    modport source (
        output valid, new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y,
               new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y, contact_status,
        input  ready
    );
    modport sink (
        input  valid, new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y,
               new_pos_b_x, new_pos_b_y, new_vel_b_x, new_vel_b_y, contact_status,
        output ready
    );
endinterface

// File: src/cpcr_sqrt_step.sv
// ----------------------------------------------------------------------------
// cpcr_sqrt_step
// One digit of the restoring integer square root: two radicand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
module cpcr_sqrt_step
    import cpcr_pkg::*;
(
    input  rec_t cur,
    output rec_t nxt
);

    logic [35:0] part;
    logic [35:0] trial;

    always_comb
    begin
        nxt   = cur;
        part  = {cur.srem, cur.rad[63:62]};
        trial = {2'b00, cur.root, 2'b01};
        if (part >= trial)
        begin
            nxt.srem = 34'(part - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.srem = part[33:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        nxt.rad = {cur.rad[61:0], 2'b00};
    end

endmodule

// File: src/cpcr_div_step.sv
// ----------------------------------------------------------------------------
// cpcr_div_step
// One quotient bit of the four restoring dividers: both normal components
// over the distance and both mass ratios over the mass sum.
// ----------------------------------------------------------------------------
module cpcr_div_step
    import cpcr_pkg::*;
(
    input  rec_t cur,
    output rec_t nxt
);

    logic [3:0][32:0] part;
    logic [3:0][32:0] den;
    logic [3:0]       qbit;

    always_comb
    begin
        nxt = cur;
        for (int k = 0; k < 4; k++)
        begin
            // lanes 0 and 1 divide by the distance, 2 and 3 by the mass sum
            den[k]  = (k < 2) ? {1'b0, cur.root} : {1'b0, cur.msum};
            part[k] = {cur.rem[k], cur.quo[k][QW-1]};
            qbit[k] = (part[k] >= den[k]);
            nxt.rem[k] = qbit[k] ? 32'(part[k] - den[k]) : part[k][31:0];
            nxt.quo[k] = {cur.quo[k][QW-2:0], qbit[k]};
        end
    end

endmodule

// File: src/circle_pair_collision_resolve_top.sv
// Throughput: one pair per cycle while the skid entry is empty; the square root takes one bit per
// stage over 32 stages and the four dividers one quotient bit per stage over 30 stages.
// A two-entry output buffer lets the pipeline take one more pair while a result
// waits; the pipeline then holds until the buffer drains.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve_top
// Contact test and elastic resolution of a circle pair along the line of
// centers, pushing the circles apart by half of the overlap each.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve_top
    import cpcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cpcr_pair_if.sink         pair,
    cpcr_result_if.source     result
);

    localparam int P_IN       = 0;
    localparam int P_SQ       = P_IN + 1;
    localparam int P_CMP      = P_SQ + 1;
    localparam int P_SQRT0    = P_CMP + 1;
    localparam int P_PREP     = P_SQRT0 + ROOT_W;
    localparam int P_DIV0     = P_PREP + 1;
    localparam int P_SIGN     = P_DIV0 + QW;
    localparam int P_MUL1     = P_SIGN + 1;
    localparam int P_RND1     = P_MUL1 + 1;
    localparam int P_MUL2     = P_RND1 + 1;
    localparam int P_RND2     = P_MUL2 + 1;
    localparam int P_MUL3     = P_RND2 + 1;
    localparam int P_RND3     = P_MUL3 + 1;
    localparam int P_OUT      = P_RND3 + 1;
    localparam int NUM_STAGES = P_OUT + 1;
    localparam int LAST       = NUM_STAGES - 1;

    rec_t                  pipe_reg  [NUM_STAGES];
    rec_t                  pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;

    out_t last_out;
    out_t out_reg;
    out_t skid_reg;
    logic out_vld_reg;
    logic skid_vld_reg;
    logic adv;
    logic incoming;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [64:0]        slo;
    logic signed [63:0] sum_u;
    logic signed [63:0] sum_px;
    logic signed [63:0] sum_py;

    assign adv        = !skid_vld_reg;
    assign incoming   = vld_reg[LAST] && adv;
    assign pair.ready = adv;

    // input stage: differences, magnitudes and sums
    always_comb
    begin
        pipe_next[P_IN]      = '0;
        pipe_next[P_IN].pa_x = pair.pos_a_x;
        pipe_next[P_IN].pa_y = pair.pos_a_y;
        pipe_next[P_IN].va_x = pair.vel_a_x;
        pipe_next[P_IN].va_y = pair.vel_a_y;
        pipe_next[P_IN].pb_x = pair.pos_b_x;
        pipe_next[P_IN].pb_y = pair.pos_b_y;
        pipe_next[P_IN].vb_x = pair.vel_b_x;
        pipe_next[P_IN].vb_y = pair.vel_b_y;
        pipe_next[P_IN].ma   = pair.mass_a;
        pipe_next[P_IN].mb   = pair.mass_b;
        dx = 33'(pair.pos_a_x) - 33'(pair.pos_b_x);
        dy = 33'(pair.pos_a_y) - 33'(pair.pos_b_y);
        pipe_next[P_IN].neg_x = dx[32];
        pipe_next[P_IN].neg_y = dy[32];
        pipe_next[P_IN].ax    = dx[32] ? 32'(-dx) : dx[31:0];
        pipe_next[P_IN].ay    = dy[32] ? 32'(-dy) : dy[31:0];
        pipe_next[P_IN].rsum  = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
        pipe_next[P_IN].msum  = {1'b0, pair.mass_a} + {1'b0, pair.mass_b};
    end

    always_comb
    begin
        pipe_next[P_SQ]     = pipe_reg[P_SQ-1];
        pipe_next[P_SQ].sqx = pipe_reg[P_SQ-1].ax * pipe_reg[P_SQ-1].ax;
        pipe_next[P_SQ].sqy = pipe_reg[P_SQ-1].ay * pipe_reg[P_SQ-1].ay;
        pipe_next[P_SQ].rr  = pipe_reg[P_SQ-1].rsum * pipe_reg[P_SQ-1].rsum;
    end

    // contact test on exact squares
    always_comb
    begin
        pipe_next[P_CMP] = pipe_reg[P_CMP-1];
        slo = {1'b0, pipe_reg[P_CMP-1].sqx} + {1'b0, pipe_reg[P_CMP-1].sqy};
        priority if (slo > {1'b0, pipe_reg[P_CMP-1].rr})
            pipe_next[P_CMP].status = ST_NONE;
        else if (slo == '0)
            pipe_next[P_CMP].status = ST_COINCIDENT;
        else
            pipe_next[P_CMP].status = ST_RESOLVED;
        pipe_next[P_CMP].rad  = slo[63:0];
        pipe_next[P_CMP].srem = '0;
        pipe_next[P_CMP].root = '0;
    end

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        cpcr_sqrt_step u_sqrt (
            .cur (pipe_reg[P_SQRT0+g-1]),
            .nxt (pipe_next[P_SQRT0+g])
        );
    end

    // dividends with the half divisor added for rounding
    always_comb
    begin
        logic [60:0] n0;
        logic [60:0] n1;
        logic [60:0] n2;
        logic [60:0] n3;
        pipe_next[P_PREP] = pipe_reg[P_PREP-1];
        n0 = {1'b0, pipe_reg[P_PREP-1].ax, 28'd0} + 61'(pipe_reg[P_PREP-1].root >> 1);
        n1 = {1'b0, pipe_reg[P_PREP-1].ay, 28'd0} + 61'(pipe_reg[P_PREP-1].root >> 1);
        n2 = {1'b0, pipe_reg[P_PREP-1].mb, 29'd0} + 61'(pipe_reg[P_PREP-1].msum >> 1);
        n3 = {1'b0, pipe_reg[P_PREP-1].ma, 29'd0} + 61'(pipe_reg[P_PREP-1].msum >> 1);
        pipe_next[P_PREP].rem[0] = {1'b0, n0[60:QW]};
        pipe_next[P_PREP].rem[1] = {1'b0, n1[60:QW]};
        pipe_next[P_PREP].rem[2] = {1'b0, n2[60:QW]};
        pipe_next[P_PREP].rem[3] = {1'b0, n3[60:QW]};
        pipe_next[P_PREP].quo[0] = n0[QW-1:0];
        pipe_next[P_PREP].quo[1] = n1[QW-1:0];
        pipe_next[P_PREP].quo[2] = n2[QW-1:0];
        pipe_next[P_PREP].quo[3] = n3[QW-1:0];
        pipe_next[P_PREP].pen    = pipe_reg[P_PREP-1].rsum - pipe_reg[P_PREP-1].root;
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        cpcr_div_step u_div (
            .cur (pipe_reg[P_DIV0+g-1]),
            .nxt (pipe_next[P_DIV0+g])
        );
    end

    always_comb
    begin
        pipe_next[P_SIGN]    = pipe_reg[P_SIGN-1];
        pipe_next[P_SIGN].nx = pipe_reg[P_SIGN-1].neg_x ? -$signed(pipe_reg[P_SIGN-1].quo[0])
                                                        : $signed(pipe_reg[P_SIGN-1].quo[0]);
        pipe_next[P_SIGN].ny = pipe_reg[P_SIGN-1].neg_y ? -$signed(pipe_reg[P_SIGN-1].quo[1])
                                                        : $signed(pipe_reg[P_SIGN-1].quo[1]);
        // both masses zero counts as equal masses
        if (pipe_reg[P_SIGN-1].msum == '0)
        begin
            pipe_next[P_SIGN].ka = K_ONE;
            pipe_next[P_SIGN].kb = K_ONE;
        end
        else
        begin
            pipe_next[P_SIGN].ka = pipe_reg[P_SIGN-1].quo[2];
            pipe_next[P_SIGN].kb = pipe_reg[P_SIGN-1].quo[3];
        end
        pipe_next[P_SIGN].dvx = 33'(pipe_reg[P_SIGN-1].va_x) - 33'(pipe_reg[P_SIGN-1].vb_x);
        pipe_next[P_SIGN].dvy = 33'(pipe_reg[P_SIGN-1].va_y) - 33'(pipe_reg[P_SIGN-1].vb_y);
    end

    always_comb
    begin
        pipe_next[P_MUL1]     = pipe_reg[P_MUL1-1];
        pipe_next[P_MUL1].prx = pipe_reg[P_MUL1-1].dvx * pipe_reg[P_MUL1-1].nx;
        pipe_next[P_MUL1].pry = pipe_reg[P_MUL1-1].dvy * pipe_reg[P_MUL1-1].ny;
        pipe_next[P_MUL1].ppx = $signed({1'b0, pipe_reg[P_MUL1-1].pen}) * pipe_reg[P_MUL1-1].nx;
        pipe_next[P_MUL1].ppy = $signed({1'b0, pipe_reg[P_MUL1-1].pen}) * pipe_reg[P_MUL1-1].ny;
    end

    // round half up: add half an lsb, then arithmetic shift
    always_comb
    begin
        pipe_next[P_RND1] = pipe_reg[P_RND1-1];
        sum_u  = 64'(pipe_reg[P_RND1-1].prx) + 64'(pipe_reg[P_RND1-1].pry)
               + (64'sd1 <<< (NB - 1));
        sum_px = 64'(pipe_reg[P_RND1-1].ppx) + (64'sd1 <<< NB);
        sum_py = 64'(pipe_reg[P_RND1-1].ppy) + (64'sd1 <<< NB);
        pipe_next[P_RND1].u  = 36'(sum_u >>> NB);
        pipe_next[P_RND1].px = 33'(sum_px >>> (NB + 1));
        pipe_next[P_RND1].py = 33'(sum_py >>> (NB + 1));
    end

    always_comb
    begin
        pipe_next[P_MUL2]     = pipe_reg[P_MUL2-1];
        pipe_next[P_MUL2].pja = $signed({1'b0, pipe_reg[P_MUL2-1].ka}) * pipe_reg[P_MUL2-1].u;
        pipe_next[P_MUL2].pjb = $signed({1'b0, pipe_reg[P_MUL2-1].kb}) * pipe_reg[P_MUL2-1].u;
    end

    always_comb
    begin
        pipe_next[P_RND2]    = pipe_reg[P_RND2-1];
        pipe_next[P_RND2].ja = 36'((pipe_reg[P_RND2-1].pja + (64'sd1 <<< (NB - 1))) >>> NB);
        pipe_next[P_RND2].jb = 36'((pipe_reg[P_RND2-1].pjb + (64'sd1 <<< (NB - 1))) >>> NB);
    end

    always_comb
    begin
        pipe_next[P_MUL3]     = pipe_reg[P_MUL3-1];
        pipe_next[P_MUL3].qax = pipe_reg[P_MUL3-1].ja * pipe_reg[P_MUL3-1].nx;
        pipe_next[P_MUL3].qay = pipe_reg[P_MUL3-1].ja * pipe_reg[P_MUL3-1].ny;
        pipe_next[P_MUL3].qbx = pipe_reg[P_MUL3-1].jb * pipe_reg[P_MUL3-1].nx;
        pipe_next[P_MUL3].qby = pipe_reg[P_MUL3-1].jb * pipe_reg[P_MUL3-1].ny;
    end

    always_comb
    begin
        pipe_next[P_RND3]     = pipe_reg[P_RND3-1];
        pipe_next[P_RND3].dax = 36'((pipe_reg[P_RND3-1].qax + (64'sd1 <<< (NB - 1))) >>> NB);
        pipe_next[P_RND3].day = 36'((pipe_reg[P_RND3-1].qay + (64'sd1 <<< (NB - 1))) >>> NB);
        pipe_next[P_RND3].dbx = 36'((pipe_reg[P_RND3-1].qbx + (64'sd1 <<< (NB - 1))) >>> NB);
        pipe_next[P_RND3].dby = 36'((pipe_reg[P_RND3-1].qby + (64'sd1 <<< (NB - 1))) >>> NB);
    end

    // no contact and coincident centers pass the inputs through
    always_comb
    begin
        pipe_next[P_OUT] = pipe_reg[P_OUT-1];
        if (pipe_reg[P_OUT-1].status == ST_RESOLVED)
        begin
            pipe_next[P_OUT].pa_x = sat32(38'(pipe_reg[P_OUT-1].pa_x) + 38'(pipe_reg[P_OUT-1].px));
            pipe_next[P_OUT].pa_y = sat32(38'(pipe_reg[P_OUT-1].pa_y) + 38'(pipe_reg[P_OUT-1].py));
            pipe_next[P_OUT].pb_x = sat32(38'(pipe_reg[P_OUT-1].pb_x) - 38'(pipe_reg[P_OUT-1].px));
            pipe_next[P_OUT].pb_y = sat32(38'(pipe_reg[P_OUT-1].pb_y) - 38'(pipe_reg[P_OUT-1].py));
            pipe_next[P_OUT].va_x = sat32(38'(pipe_reg[P_OUT-1].va_x) - 38'(pipe_reg[P_OUT-1].dax));
            pipe_next[P_OUT].va_y = sat32(38'(pipe_reg[P_OUT-1].va_y) - 38'(pipe_reg[P_OUT-1].day));
            pipe_next[P_OUT].vb_x = sat32(38'(pipe_reg[P_OUT-1].vb_x) + 38'(pipe_reg[P_OUT-1].dbx));
            pipe_next[P_OUT].vb_y = sat32(38'(pipe_reg[P_OUT-1].vb_y) + 38'(pipe_reg[P_OUT-1].dby));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAST-1:0], pair.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    always_comb
    begin
        last_out.pa_x   = pipe_reg[LAST].pa_x;
        last_out.pa_y   = pipe_reg[LAST].pa_y;
        last_out.va_x   = pipe_reg[LAST].va_x;
        last_out.va_y   = pipe_reg[LAST].va_y;
        last_out.pb_x   = pipe_reg[LAST].pb_x;
        last_out.pb_y   = pipe_reg[LAST].pb_y;
        last_out.vb_x   = pipe_reg[LAST].vb_x;
        last_out.vb_y   = pipe_reg[LAST].vb_y;
        last_out.status = pipe_reg[LAST].status;
    end

    // output register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_vld_reg  <= incoming || skid_vld_reg;
            skid_vld_reg <= 1'b0;
        end
        else if (incoming)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || result.ready)
            out_reg <= skid_vld_reg ? skid_reg : last_out;
        else if (incoming)
            skid_reg <= last_out;
    end

    assign result.valid          = out_vld_reg;
    assign result.new_pos_a_x    = out_reg.pa_x;
    assign result.new_pos_a_y    = out_reg.pa_y;
    assign result.new_vel_a_x    = out_reg.va_x;
    assign result.new_vel_a_y    = out_reg.va_y;
    assign result.new_pos_b_x    = out_reg.pb_x;
    assign result.new_pos_b_y    = out_reg.pb_y;
    assign result.new_vel_b_x    = out_reg.vb_x;
    assign result.new_vel_b_y    = out_reg.vb_y;
    assign result.contact_status = out_reg.status;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry full while output register empty");

    a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !result.ready && incoming |=> skid_vld_reg)
        else $error("item leaving the pipeline under stall was dropped");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_SIGN] && pipe_reg[P_SIGN].status == ST_RESOLVED |->
        (pipe_reg[P_SIGN].nx <= $signed(K_ONE)) && (pipe_reg[P_SIGN].nx >= -$signed(K_ONE)))
        else $error("normal component exceeds unit length");

endmodule

// File: tb/sv/tb_circle_pair_collision_resolve_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolve_top
// Drives circle pairs into the resolver and compares every result item with
// a bit-exact predictor of contact test, elastic response and push apart.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolve_top
    import cpcr_pkg::*;
();

    localparam int NBITS     = 28;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 930;

    typedef struct {
        logic signed [31:0] pax, pay, vax, vay;
        logic [30:0]        ma, ra;
        logic signed [31:0] pbx, pby, vbx, vby;
        logic [30:0]        mb, rb;
    } pair_t;

    logic clk;
    logic rst_n;

    cpcr_pair_if   pair_ch ();
    cpcr_result_if res_ch ();

    circle_pair_collision_resolve_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (res_ch.source)
    );

    pair_t  pending_pairs[$];
    out_t   expected_results[$];
    int     mismatches;
    int     idle_phase;
    int     hold_off;
    int     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_sh(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint round_sh(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint div_rnd(longint num, longint unsigned den);
        longint unsigned a;
        longint unsigned q;
        a = (num < 0) ? longint'(-num) : num;
        q = (a + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic out_t resolve_pair(pair_t p);
        longint pax, pay, vax, vay, pbx, pby, vbx, vby, dx, dy;
        longint unsigned ax, ay, sx, sy, slo, rsum, d, msum;
        longint nx, ny, ka, kb, u, ja, jb, pen, px, py;
        longint npax, npay, nvax, nvay, npbx, npby, nvbx, nvby;
        bit hi;
        out_t o;
        pax = p.pax; pay = p.pay; vax = p.vax; vay = p.vay;
        pbx = p.pbx; pby = p.pby; vbx = p.vbx; vby = p.vby;
        npax = pax; npay = pay; nvax = vax; nvay = vay;
        npbx = pbx; npby = pby; nvbx = vbx; nvby = vby;
        dx = pax - pbx;
        dy = pay - pby;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sx = ax * ax;
        sy = ay * ay;
        slo = sx + sy;
        hi = slo < sx;
        rsum = longint'(p.ra) + longint'(p.rb);
        if (hi || slo > rsum * rsum)
            o.status = ST_NONE;
        else if (slo == 0)
            o.status = ST_COINCIDENT;
        else
        begin
            d = int_sqrt(slo);
            nx = div_rnd(longint'(ax << NBITS) * ((dx < 0) ? -1 : 1), d);
            ny = div_rnd(longint'(ay << NBITS) * ((dy < 0) ? -1 : 1), d);
            msum = longint'(p.ma) + longint'(p.mb);
            if (msum == 0)
            begin
                ka = longint'(1) << NBITS;
                kb = ka;
            end
            else
            begin
                ka = div_rnd((longint'(p.mb) * 2) << NBITS, msum);
                kb = div_rnd((longint'(p.ma) * 2) << NBITS, msum);
            end
            u = round_sh((vax - vbx) * nx + (vay - vby) * ny, NBITS);
            ja = round_sh(ka * u, NBITS);
            jb = round_sh(kb * u, NBITS);
            nvax = vax - round_sh(ja * nx, NBITS);
            nvay = vay - round_sh(ja * ny, NBITS);
            nvbx = vbx + round_sh(jb * nx, NBITS);
            nvby = vby + round_sh(jb * ny, NBITS);
            pen = longint'(rsum - d);
            px = round_sh(pen * nx, NBITS + 1);
            py = round_sh(pen * ny, NBITS + 1);
            npax = pax + px; npay = pay + py;
            npbx = pbx - px; npby = pby - py;
            o.status = ST_RESOLVED;
        end
        o.pa_x = clamp32(npax); o.pa_y = clamp32(npay);
        o.va_x = clamp32(nvax); o.va_y = clamp32(nvay);
        o.pb_x = clamp32(npbx); o.pb_y = clamp32(npby);
        o.vb_x = clamp32(nvbx); o.vb_y = clamp32(nvby);
        return o;
    endfunction

    function automatic logic signed [31:0] rand_s32(int lim);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            default: v = $signed($urandom_range(0, 2 * lim)) - lim;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] rand_u31(int lim);
        if ($urandom_range(0, 7) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, lim));
    endfunction

    // mostly touching pairs at moderate scale, some wild noise
    function automatic pair_t rand_pair();
        pair_t p;
        int    sc;
        int    r;
        sc = 1 << $urandom_range(8, 24);
        p.pax = rand_s32(sc * 4); p.pay = rand_s32(sc * 4);
        p.vax = rand_s32(sc * 8); p.vay = rand_s32(sc * 8);
        p.ma = rand_u31(sc * 4); p.mb = rand_u31(sc * 4);
        p.ra = rand_u31(sc); p.rb = rand_u31(sc);
        p.vbx = rand_s32(sc * 8); p.vby = rand_s32(sc * 8);
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            p.pbx = p.pax + $signed($urandom_range(0, 2 * sc)) - sc;
            p.pby = p.pay + $signed($urandom_range(0, 2 * sc)) - sc;
        end
        else if (r == 7)
        begin
            p.pbx = p.pax;
            p.pby = p.pay;
        end
        else
        begin
            p.pbx = $urandom;
            p.pby = $urandom;
        end
        return p;
    endfunction

    task automatic add_pair(pair_t p);
        pending_pairs.push_back(p);
        expected_results.push_back(resolve_pair(p));
    endtask

    initial
    begin
        pair_t p;
        rst_n = 1'b0;
        hold_off = 0;
        // directed: no contact, coincident, zero masses, extremes
        p = '{0, 0, 100, 0, 65536, 65536, 200000, 0, 0, 0, 65536, 65536};
        add_pair(p);
        p = '{0, 0, 100, 0, 65536, 65536, 100000, 0, -100, 0, 65536, 65536};
        add_pair(p);
        p = '{5, 5, 1, 2, 3, 9, 5, 5, 4, 5, 6, 9};
        add_pair(p);
        p = '{0, 0, 1000, 300, 0, 40, 30, 40, -1000, 0, 0, 40};
        add_pair(p);
        p = '{0, 0, 1000, 300, 0, 40, 30, 40, -1000, 0, 77, 40};
        add_pair(p);
        p = '{0, 0, 1000, 300, 77, 40, -30, -40, -1000, 0, 0, 40};
        add_pair(p);
        p = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              31'h7fff_ffff, 31'h7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff};
        add_pair(p);
        p = '{32'sh7fff_ff00, 0, 32'sh7fff_ffff, 0, 1, 31'h7fff_ffff,
              32'sh7fff_fe00, 0, 32'sh8000_0000, 0, 31'h7fff_ffff, 31'h7fff_ffff};
        add_pair(p);
        p = '{32'sh8000_0000, 32'sh8000_0000, -1, -1, 1, 0,
              32'sh8000_0000, 32'sh8000_0001, 1, 1, 1, 1};
        add_pair(p);
        p = '{1, 0, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 1,
              0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0};
        add_pair(p);
        p = '{-3, 4, 0, 0, 2, 0, 0, 0, 0, 0, 2, 0};
        add_pair(p);
        for (int i = 0; i < N_RANDOM; i++)
            add_pair(rand_pair());
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // phase of the idling pattern follows progress through the pairs
    always @(posedge clk)
    begin
        if (pending_pairs.size() > 2 * N_RANDOM / 3)
            idle_phase <= 0;
        else if (pending_pairs.size() > N_RANDOM / 3)
            idle_phase <= 1;
        else
            idle_phase <= 2;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_ch.valid <= 1'b0;
            pair_ch.pos_a_x <= '0; pair_ch.pos_a_y <= '0;
            pair_ch.vel_a_x <= '0; pair_ch.vel_a_y <= '0;
            pair_ch.mass_a <= '0; pair_ch.radius_a <= '0;
            pair_ch.pos_b_x <= '0; pair_ch.pos_b_y <= '0;
            pair_ch.vel_b_x <= '0; pair_ch.vel_b_y <= '0;
            pair_ch.mass_b <= '0; pair_ch.radius_b <= '0;
        end
        else
        begin
            // the accepted item leaves the queue, so the next one is at the front
            if (pair_ch.valid && pair_ch.ready)
                void'(pending_pairs.pop_front());
            if (!(pair_ch.valid && !pair_ch.ready))
            begin
                if (pending_pairs.size() > 0
                    && !(idle_phase == 0 && $urandom_range(0, 99) < 24)
                    && !(idle_phase == 1 && $urandom_range(0, 99) < 80))
                begin
                    pair_t p;
                    p = pending_pairs[0];
                    pair_ch.valid <= 1'b1;
                    pair_ch.pos_a_x <= p.pax; pair_ch.pos_a_y <= p.pay;
                    pair_ch.vel_a_x <= p.vax; pair_ch.vel_a_y <= p.vay;
                    pair_ch.mass_a <= p.ma; pair_ch.radius_a <= p.ra;
                    pair_ch.pos_b_x <= p.pbx; pair_ch.pos_b_y <= p.pby;
                    pair_ch.vel_b_x <= p.vbx; pair_ch.vel_b_y <= p.vby;
                    pair_ch.mass_b <= p.mb; pair_ch.radius_b <= p.rb;
                end
                else
                    pair_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off once the pending queue is down to N_RANDOM / 2 pairs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_off <= 0;
        end
        else if (hold_off == 0 && pending_pairs.size() == N_RANDOM / 2)
        begin
            hold_off <= 400;
            res_ch.ready <= 1'b0;
        end
        else if (hold_off > 1)
        begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_off == 1)
                hold_off <= -1;
            if (idle_phase == 0)
                res_ch.ready <= $urandom_range(0, 99) >= 80;
            else if (idle_phase == 1)
                res_ch.ready <= $urandom_range(0, 99) >= 24;
            else
                res_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item status %0d", res_ch.contact_status);
            end
            else
            begin
                out_t e;
                e = expected_results.pop_front();
                if (res_ch.new_pos_a_x !== e.pa_x || res_ch.new_pos_a_y !== e.pa_y
                    || res_ch.new_vel_a_x !== e.va_x || res_ch.new_vel_a_y !== e.va_y
                    || res_ch.new_pos_b_x !== e.pb_x || res_ch.new_pos_b_y !== e.pb_y
                    || res_ch.new_vel_b_x !== e.vb_x || res_ch.new_vel_b_y !== e.vb_y
                    || res_ch.contact_status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d %0d %0d %0d st %0d",
                                 e.pa_x, e.pa_y, e.va_x, e.va_y, e.pb_x, e.pb_y,
                                 e.vb_x, e.vb_y, e.status,
                                 " got %0d %0d %0d %0d %0d %0d %0d %0d st %0d",
                                 res_ch.new_pos_a_x, res_ch.new_pos_a_y,
                                 res_ch.new_vel_a_x, res_ch.new_vel_a_y,
                                 res_ch.new_pos_b_x, res_ch.new_pos_b_y,
                                 res_ch.new_vel_b_x, res_ch.new_vel_b_y,
                                 res_ch.contact_status);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        mismatches = 0;
        quiet_cycles = 0;
    end

endmodule

// File: circle_pair_collision_resolve_top.f
src/cpcr_pkg.sv
src/cpcr_if.sv
src/cpcr_sqrt_step.sv
src/cpcr_div_step.sv
src/circle_pair_collision_resolve_top.sv
tb/sv/tb_circle_pair_collision_resolve_top.sv
